// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the sparse set RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// ssm_pkg
// Widths, codes and types shared by the sparse set membership block.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Store sizes.
  localparam int ENTITY_W       = 10;
  localparam int MAX_ENTITIES   = 1 << ENTITY_W;
  localparam int DENSE_CAPACITY = 256;
  localparam int SLOT_W         = $clog2(DENSE_CAPACITY);
  localparam int COUNT_W        = $clog2(DENSE_CAPACITY + 1);
  localparam int STATUS_W       = 2;

  typedef logic [ENTITY_W-1:0] entity_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Operation codes.
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes.
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_PRESENT = 2'd2;
  localparam status_t ST_ABSENT  = 2'd3;

endpackage

// ----- hw/rtl/ssm_ram.sv -----
// ----------------------------------------------------------------------------
// ssm_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ssm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/sparse_set_membership.sv -----
// ----------------------------------------------------------------------------
// sparse_set_membership
// Sparse set of entity ids with add and swap-remove, held in two RAMs.
// ----------------------------------------------------------------------------
// Each request keeps the block busy from its acceptance until its result is
// loaded. The accepting cycle starts the read of the sparse map (entity to
// slot). S_SPARSE and S_DENSE then read the dense array through its single
// read port: first the entry at the slot, for the membership test, then the
// last entry, for the swap. A final cycle, S_LAST, writes both RAMs and loads
// the output register. No new request is taken until the block is back in
// S_IDLE. A stalled result holds the block in its final cycle. One request is
// worked on at a time; the next one is accepted while the previous result
// still waits in the output register.
// A member is an entity whose sparse entry points below the member count at a
// dense entry that holds the entity, so the RAMs need no clearing after reset
// and the block is ready at once.
`include "assert_macros.svh"

module sparse_set_membership (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_operation,
  input  ssm_pkg::entity_t in_entity,
  output logic             out_valid,
  input  logic             out_stall,
  output ssm_pkg::status_t out_status,
  output ssm_pkg::slot_t   out_slot,
  output logic             out_moved_valid,
  output ssm_pkg::entity_t out_moved_entity,
  output ssm_pkg::count_t  out_count
);

  import ssm_pkg::*;

  // Sequencer state codes.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SPARSE = 2'd1;
  localparam logic [1:0] S_DENSE  = 2'd2;
  localparam logic [1:0] S_LAST   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       op_r;
  entity_t    entity_r;
  slot_t      slot_r;
  logic       member_r;
  count_t     count_r, count_nxt;

  logic       out_valid_r;
  status_t    out_status_r, out_status_nxt;
  slot_t      out_slot_r, out_slot_nxt;
  logic       out_moved_valid_r, out_moved_valid_nxt;
  entity_t    out_moved_entity_r, out_moved_entity_nxt;

  logic       accept;
  logic       finish;
  count_t     last;
  logic       member_now;

  logic       sparse_we;
  entity_t    sparse_waddr, sparse_raddr;
  slot_t      sparse_wdata, sparse_rdata;
  logic       dense_we;
  slot_t      dense_waddr, dense_raddr;
  entity_t    dense_wdata, dense_rdata;

  // Sparse map: entity to dense slot.
  ssm_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ENTITIES)) u_sparse (
    .clk   (clk),
    .we    (sparse_we),
    .waddr (sparse_waddr),
    .wdata (sparse_wdata),
    .raddr (sparse_raddr),
    .rdata (sparse_rdata)
  );

  // Dense array: slot to entity.
  ssm_ram #(.WIDTH(ENTITY_W), .DEPTH(DENSE_CAPACITY)) u_dense (
    .clk   (clk),
    .we    (dense_we),
    .waddr (dense_waddr),
    .wdata (dense_wdata),
    .raddr (dense_raddr),
    .rdata (dense_rdata)
  );

  // Handshake and sequencing conditions.
  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign finish     = (state_r == S_LAST) && (!out_valid_r || !out_stall);
  assign last       = count_r - count_t'(1);
  assign member_now = ({1'b0, slot_r} < count_r) && (dense_rdata == entity_r);

  // RAM read addresses: sparse map at the entity, dense array at the slot
  // found there and then at the last occupied slot. The last slot stays
  // addressed while the final cycle waits, so its entry is still there.
  assign sparse_raddr = accept ? in_entity : entity_r;

  always_comb begin
    unique case (state_r)
      S_SPARSE: dense_raddr = sparse_rdata;
      default:  dense_raddr = last[SLOT_W-1:0];
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_SPARSE;
      S_SPARSE: state_nxt = S_DENSE;
      S_DENSE:  state_nxt = S_LAST;
      S_LAST:   if (finish) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Final cycle: decide the outcome, write back both stores, build the result.
  always_comb begin
    sparse_we            = 1'b0;
    sparse_waddr         = entity_r;
    sparse_wdata         = count_r[SLOT_W-1:0];
    dense_we             = 1'b0;
    dense_waddr          = count_r[SLOT_W-1:0];
    dense_wdata          = entity_r;
    count_nxt            = count_r;
    out_status_nxt       = ST_OK;
    out_slot_nxt         = '0;
    out_moved_valid_nxt  = 1'b0;
    out_moved_entity_nxt = '0;
    if (op_r == OP_ADD) begin
      if (member_r) begin
        out_status_nxt = ST_PRESENT;
        out_slot_nxt   = slot_r;
      end else if (count_r >= count_t'(DENSE_CAPACITY)) begin
        out_status_nxt = ST_FULL;
      end else begin
        // Append at the end of the dense array.
        sparse_we    = finish;
        dense_we     = finish;
        out_slot_nxt = count_r[SLOT_W-1:0];
        count_nxt    = count_r + count_t'(1);
      end
    end else begin
      if (!member_r) begin
        out_status_nxt = ST_ABSENT;
      end else begin
        out_slot_nxt = slot_r;
        count_nxt    = last;
        // Move the last entity into the freed slot unless it was the last.
        if ({1'b0, slot_r} < last) begin
          sparse_we            = finish;
          sparse_waddr         = dense_rdata;
          sparse_wdata         = slot_r;
          dense_we             = finish;
          dense_waddr          = slot_r;
          dense_wdata          = dense_rdata;
          out_moved_valid_nxt  = 1'b1;
          out_moved_entity_nxt = dense_rdata;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      entity_r <= in_entity;
    end
    if (state_r == S_SPARSE) begin
      slot_r <= sparse_rdata;
    end
    if (state_r == S_DENSE) begin
      member_r <= member_now;
    end
    if (finish) begin
      out_status_r       <= out_status_nxt;
      out_slot_r         <= out_slot_nxt;
      out_moved_valid_r  <= out_moved_valid_nxt;
      out_moved_entity_r <= out_moved_entity_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_moved_valid  = out_moved_valid_r;
  assign out_moved_entity = out_moved_entity_r;
  assign out_count        = count_r;

  // Checks on the sequencer and the member count.
  `ASSERT_NEXT(a_accept_starts_read, clk, rst_n, accept, state_r == S_SPARSE)
  `ASSERT_IMPLIES(a_write_only_at_end, clk, rst_n, sparse_we || dense_we, finish)
  `ASSERT_IMPLIES(a_count_bounded, clk, rst_n, 1'b1, count_r <= count_t'(DENSE_CAPACITY))
  `ASSERT_IMPLIES(a_result_from_end, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_LAST)
  `ASSERT_NEXT(a_remove_shrinks, clk, rst_n, finish && (op_r == OP_REMOVE) && member_r, count_r == $past(last))

endmodule
